FILE: hdl/mre_pkg.sv
`default_nettype none
package mre_pkg;

   localparam int LIST_DEPTH     = 256;
   localparam int RUN_COUNT_BITS = 16;
   localparam int IDX_W          = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int FILL_W         = $clog2(LIST_DEPTH + 1);
   localparam int MAX_OUT        = 4;

   localparam logic [7:0] TOKEN_BASE = 8'h80;
   localparam logic [7:0] TOKEN_ONE  = 8'h81;
   localparam int         RUN_MIN    = 3;

   typedef enum logic [2:0] {
      F_IDLE,
      F_RD,
      F_CMP,
      F_MRD,
      F_MWR,
      F_NEW,
      F_PUSH
   } front_state_type;

   typedef struct packed {
      logic [7:0] token;
      logic [7:0] data;
      logic       literal;
      logic       run_tok;
      logic       fin;
   } record_type;

   function automatic logic [7:0] pos_token(input logic [FILL_W-1:0] pos);
      logic [7:0] low;
      low = 8'(pos);
      return TOKEN_BASE + low;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/mre_channels.sv
`default_nettype none
interface mre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       final_byte;
   modport source (output valid, output in_byte, output final_byte, input ready);
   modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface mre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   modport source (output valid, output out_byte, output run_end, input ready);
   modport sink (input valid, input out_byte, input run_end, output ready);
endinterface
`default_nettype wire

FILE: hdl/mre_ram.sv
`default_nettype none
module mre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH)-1:0]         waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [$clog2(DEPTH)-1:0]         raddr,
   output logic      [WIDTH-1:0]                 rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule
`default_nettype wire

FILE: hdl/mre_front.sv
`default_nettype none
module mre_front (
   input  wire logic               clock,
   input  wire logic               reset,
   mre_req_if.sink                 req_chan,
   output mre_pkg::record_type     push_rec,
   output logic                    push_valid,
   input  wire logic               push_ready
);

   mre_pkg::front_state_type state_ff, state_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       fin_ff, fin_in;
   logic [mre_pkg::FILL_W-1:0] idx_ff, idx_in;
   logic [mre_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [mre_pkg::FILL_W-1:0] pos_ff, pos_in;
   logic                       lit_ff, lit_in;
   logic                       run_ff, run_in;

   logic                      we;
   logic [mre_pkg::IDX_W-1:0] waddr, raddr;
   logic [7:0]                wdata, rdata;

   mre_ram #(.WIDTH(8), .DEPTH(mre_pkg::LIST_DEPTH)) u_list (
      .clock    (clock),
      .we       (we),
      .waddr    (waddr),
      .wdata    (wdata),
      .raddr    (raddr),
      .rdata_ff (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mre_pkg::F_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      byte_ff <= byte_in;
      fin_ff  <= fin_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      lit_ff  <= lit_in;
      run_ff  <= run_in;
   end

   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      fin_in   = fin_ff;
      idx_in   = idx_ff;
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      lit_in   = lit_ff;
      run_in   = run_ff;
      we       = 1'b0;
      waddr    = idx_ff[mre_pkg::IDX_W-1:0];
      wdata    = byte_ff;
      raddr    = idx_ff[mre_pkg::IDX_W-1:0];
      req_chan.ready = 1'b0;
      push_valid     = 1'b0;
      unique case (state_ff)
         mre_pkg::F_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               byte_in = req_chan.in_byte;
               fin_in  = req_chan.final_byte;
               idx_in  = '0;
               state_in = (fill_ff == '0) ? mre_pkg::F_NEW : mre_pkg::F_RD;
            end
         end
         mre_pkg::F_RD: begin
            state_in = mre_pkg::F_CMP;
         end
         mre_pkg::F_CMP: begin
            if (rdata == byte_ff) begin
               pos_in = idx_ff + 1'b1;
               run_in = (idx_ff == '0);
               lit_in = 1'b0;
               state_in = mre_pkg::F_MRD;
            end else if (idx_ff + 1'b1 == fill_ff) begin
               state_in = mre_pkg::F_NEW;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = mre_pkg::F_RD;
            end
         end
         mre_pkg::F_MRD: begin
            if (idx_ff == '0) begin
               we    = 1'b1;
               waddr = '0;
               state_in = mre_pkg::F_PUSH;
            end else begin
               raddr = mre_pkg::IDX_W'(idx_ff - 1'b1);
               state_in = mre_pkg::F_MWR;
            end
         end
         mre_pkg::F_MWR: begin
            we     = 1'b1;
            wdata  = rdata;
            idx_in = idx_ff - 1'b1;
            state_in = mre_pkg::F_MRD;
         end
         mre_pkg::F_NEW: begin
            we = 1'b1;
            if (fill_ff < mre_pkg::FILL_W'(mre_pkg::LIST_DEPTH)) begin
               waddr   = fill_ff[mre_pkg::IDX_W-1:0];
               fill_in = fill_ff + 1'b1;
               pos_in  = fill_ff + 1'b1;
            end else begin
               waddr  = mre_pkg::IDX_W'(mre_pkg::LIST_DEPTH - 1);
               pos_in = mre_pkg::FILL_W'(mre_pkg::LIST_DEPTH);
            end
            run_in = (fill_ff == '0) && (byte_ff == 8'd0);
            lit_in = (byte_ff != 8'd0);
            state_in = mre_pkg::F_PUSH;
         end
         mre_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = mre_pkg::F_IDLE;
            end
         end
         default: state_in = mre_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      push_rec.token   = mre_pkg::pos_token(pos_ff);
      push_rec.data    = byte_ff;
      push_rec.literal = lit_ff;
      push_rec.run_tok = run_ff;
      push_rec.fin     = fin_ff;
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= mre_pkg::FILL_W'(mre_pkg::LIST_DEPTH))
      else $error("list fill beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mre_pkg::F_PUSH && push_ready) |=> state_ff == mre_pkg::F_IDLE)
      else $error("front did not return to idle after push");
`endif

endmodule
`default_nettype wire

FILE: hdl/mre_queue.sv
`default_nettype none
module mre_queue (
   input  wire logic           clock,
   input  wire logic           reset,
   input  mre_pkg::record_type push_rec,
   input  wire logic           push_valid,
   output logic                push_ready,
   output mre_pkg::record_type pop_rec,
   output logic                pop_valid,
   input  wire logic           pop_ready
);

   mre_pkg::record_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_rec    = ent_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_rec;
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

FILE: hdl/mre_back.sv
`default_nettype none
module mre_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  mre_pkg::record_type pop_rec,
   input  wire logic           pop_valid,
   output logic                pop_ready,
   mre_rsp_if.source           rsp_chan
);

   logic [mre_pkg::RUN_COUNT_BITS-1:0] ones_run_ff, ones_run_in;
   logic       busy_ff, busy_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] buf_ff [mre_pkg::MAX_OUT];
   logic [7:0] buf_in [mre_pkg::MAX_OUT];

   logic [mre_pkg::RUN_COUNT_BITS-1:0] run_inc, run_val;
   logic       do_flush, take, last;
   logic [2:0] n;

   assign pop_ready      = !busy_ff;
   assign take           = pop_valid && !busy_ff;
   assign last           = (idx_ff == 2'(cnt_ff - 3'd1));
   assign rsp_chan.valid    = busy_ff;
   assign rsp_chan.out_byte = buf_ff[idx_ff];
   assign rsp_chan.run_end  = last;

   always_comb begin
      run_inc  = (&ones_run_ff) ? ones_run_ff : ones_run_ff + 1'b1;
      run_val  = pop_rec.run_tok ? run_inc : ones_run_ff;
      do_flush = !pop_rec.run_tok || pop_rec.fin;
      n = '0;
      for (int k = 0; k < mre_pkg::MAX_OUT; k++) begin
         buf_in[k] = buf_ff[k];
      end
      if (do_flush && run_val != '0) begin
         if (run_val < mre_pkg::RUN_COUNT_BITS'(mre_pkg::RUN_MIN)) begin
            buf_in[0] = mre_pkg::TOKEN_ONE;
            n = 3'd1;
            if (run_val == mre_pkg::RUN_COUNT_BITS'(2)) begin
               buf_in[1] = mre_pkg::TOKEN_ONE;
               n = 3'd2;
            end
         end else begin
            buf_in[0] = mre_pkg::TOKEN_BASE;
            buf_in[1] = mre_pkg::TOKEN_BASE + 8'(run_val);
            n = 3'd2;
         end
      end
      if (!pop_rec.run_tok) begin
         buf_in[n[1:0]] = pop_rec.token;
         n = n + 3'd1;
         if (pop_rec.literal) begin
            buf_in[n[1:0]] = pop_rec.data;
            n = n + 3'd1;
         end
      end
      ones_run_in = ones_run_ff;
      busy_in     = busy_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      if (take) begin
         ones_run_in = do_flush ? '0 : run_inc;
         busy_in     = (n != '0);
         cnt_in      = n;
         idx_in      = '0;
      end else if (busy_ff && rsp_chan.ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_run_ff <= '0;
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
         idx_ff      <= '0;
      end else begin
         ones_run_ff <= ones_run_in;
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
      end
      if (take) begin
         for (int k = 0; k < mre_pkg::MAX_OUT; k++) begin
            buf_ff[k] <= buf_in[k];
         end
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != 3'd0 && {1'b0, idx_ff} < cnt_ff))
      else $error("output index beyond item count");
   assert property (@(posedge clock) disable iff (reset)
      (take && pop_rec.run_tok && !pop_rec.fin) |=> !busy_ff)
      else $error("run token produced output without flush");
`endif

endmodule
`default_nettype wire

FILE: hdl/mtf_rle_byte_encoder_unit.sv
// A known byte is found by a sequential search of the list memory and moved to the front by
// shifting the entries before it; a new byte is searched for across the list, then appended.
// Records pass through the queue and the output buffer; output bytes go one per cycle while ready.
// The next input byte is accepted once the record has been pushed into the queue.
// Reset is synchronous and active high; it empties the list count, the run counter
// and the queue, and leaves the list memory contents as they are.
`default_nettype none
module mtf_rle_byte_encoder_unit (
   input wire logic clock,
   input wire logic reset,
   mre_req_if.sink   req_chan,
   mre_rsp_if.source rsp_chan
);

   mre_pkg::record_type push_rec, pop_rec;
   logic push_valid, push_ready, pop_valid, pop_ready;

   mre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_rec   (push_rec),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   mre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_rec   (push_rec),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_rec    (pop_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   mre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_rec   (pop_rec),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire
